### sv/gpio_port_with_spi_temp_sensor_assert.svh
// Assertion macros shared by the GPIO port block.
`ifndef GPIO_PORT_WITH_SPI_TEMP_SENSOR_ASSERT_SVH
`define GPIO_PORT_WITH_SPI_TEMP_SENSOR_ASSERT_SVH

`ifndef SYNTHESIS
// Condition that must hold in the same cycle as the trigger.
`define GPTS_ASSERT_NOW(label, clock, rstn, trig, cond) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (trig) |-> (cond)) \
		else $error("gpio port assertion failed");
// Condition that must hold in the cycle after the trigger.
`define GPTS_ASSERT_NEXT(label, clock, rstn, trig, cond) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (trig) |=> (cond)) \
		else $error("gpio port assertion failed");
`else
`define GPTS_ASSERT_NOW(label, clock, rstn, trig, cond)
`define GPTS_ASSERT_NEXT(label, clock, rstn, trig, cond)
`endif

`endif

### sv/gpts_pkg.sv
package gpts_pkg;

	typedef enum logic {
		REQ_READ  = 1'b0,
		REQ_WRITE = 1'b1
	} req_kind_t;

	// Register word indexes.
	localparam logic [4:0] IDX_PA_OUT = 5'd0;
	localparam logic [4:0] IDX_PA_IN  = 5'd1;
	localparam logic [4:0] IDX_PA_OE  = 5'd2;
	localparam logic [4:0] IDX_PD_OUT = 5'd16;
	localparam logic [4:0] IDX_PD_IN  = 5'd17;
	localparam logic [4:0] IDX_PD_OE  = 5'd18;

	localparam logic [4:0]  SENSOR_BITS = 5'd16;
	localparam logic [16:0] TEMP_WORD   = 17'h00b9f;
	localparam logic [16:0] ID_WORD     = 17'h08100;
	localparam logic [7:0]  CMD_TEMP    = 8'h00;
	localparam logic [7:0]  CMD_ID      = 8'hff;

	typedef struct packed {
		logic [16:0] shift;
		logic [4:0]  bits_left;
		logic        in_phase;
		logic [15:0] command;
	} sensor_t;

endpackage

### sv/gpio_port_with_spi_temp_sensor.sv
// GPIO register block with a bit-banged SPI temperature sensor on port D and three latched
// flash control pins (ALE, CLE, CE) taken from bits 6, 5 and 4 of writes to port A output.
// Each request is one 32-bit register access and returns one result: read data (zero for
// writes and for indexes past the register file) plus the flash pins as they stand after
// the access. Requests pass through an input register and then a result register, and a
// result waits in its register until out_ready takes it; one request is taken every cycle
// while results are drained, and the register file write and the sensor step for a request
// finish in the single pass between the two registers. Reads of the port A and port D
// input words return the output latch ANDed with the output enable, with the flash ready
// pin at bit 7 and the sensor's serial data at bit 4 respectively.
`include "gpio_port_with_spi_temp_sensor_assert.svh"

module gpio_port_with_spi_temp_sensor #(
	parameter int NUM_REGS = 23
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [4:0]  word_index,
	input  logic [31:0] write_data,
	input  logic        flash_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        flash_ale,
	output logic        flash_cle,
	output logic        flash_ce
);
	import gpts_pkg::*;

	localparam int         IDX_W      = $clog2(NUM_REGS);
	localparam logic [5:0] NUM_REGS_W = 6'(NUM_REGS);

	logic              valid_s1;
	logic              req_type_s1;
	logic [4:0]        word_index_s1;
	logic [31:0]       write_data_s1;
	logic              flash_ready_s1;

	logic              out_valid_q;
	logic [31:0]       read_data_q;
	logic [31:0]       reg_q [NUM_REGS];
	sensor_t           sensor_q;
	logic [2:0]        flash_pins_q;

	logic              advance;
	logic              is_write;
	logic              in_range;
	logic [IDX_W-1:0]  widx;
	logic              pd_edge;
	logic              sck;
	logic              sdi;
	logic [4:0]        bits_dec;
	sensor_t           sensor_d;
	logic [2:0]        flash_d;
	logic [31:0]       rdata;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign is_write = (req_type_s1 == REQ_WRITE);
	assign in_range = ({1'b0, word_index_s1} < NUM_REGS_W);
	assign widx     = word_index_s1[IDX_W-1:0];
	assign sck      = write_data_s1[1];
	assign sdi      = write_data_s1[4];
	// The sensor only sees a clock edge when the clock bit of port D actually toggles.
	assign pd_edge  = is_write && (word_index_s1 == IDX_PD_OUT) &&
		(reg_q[IDX_PD_OUT][1] ^ write_data_s1[1]);

	always_comb begin
		sensor_d = sensor_q;
		bits_dec = '0;
		if (pd_edge) begin
			// A count of zero is only seen after reset; it starts a fresh output phase.
			if (sensor_q.bits_left == '0) begin
				sensor_d.bits_left = SENSOR_BITS;
				sensor_d.in_phase  = 1'b0;
			end
			bits_dec = sensor_d.bits_left - 5'd1;
			if (!sensor_d.in_phase) begin
				if (!sck) begin
					sensor_d.bits_left = bits_dec;
					sensor_d.shift     = {sensor_d.shift[15:0], 1'b0};
					if (bits_dec == '0) begin
						sensor_d.shift     = '0;
						sensor_d.in_phase  = 1'b1;
						sensor_d.bits_left = SENSOR_BITS;
					end
				end
			end else if (sck) begin
				sensor_d.bits_left = bits_dec;
				sensor_d.shift     = {sensor_d.shift[15:0], sdi};
				if (bits_dec == '0) begin
					sensor_d.command   = sensor_d.shift[15:0];
					sensor_d.in_phase  = 1'b0;
					sensor_d.bits_left = SENSOR_BITS;
					if (sensor_d.command[7:0] == CMD_TEMP) begin
						sensor_d.shift = TEMP_WORD;
					end else if (sensor_d.command[7:0] == CMD_ID) begin
						sensor_d.shift = ID_WORD;
					end
				end
			end
		end
	end

	always_comb begin
		flash_d = flash_pins_q;
		if (is_write && (word_index_s1 == IDX_PA_OUT)) begin
			flash_d = {write_data_s1[6], write_data_s1[5], write_data_s1[4]};
		end
	end

	always_comb begin
		rdata = '0;
		if (!is_write && in_range) begin
			if (word_index_s1 == IDX_PA_IN) begin
				rdata = (reg_q[IDX_PA_OUT] & reg_q[IDX_PA_OE]) |
					{24'b0, flash_ready_s1, 7'b0};
			end else if (word_index_s1 == IDX_PD_IN) begin
				rdata = (reg_q[IDX_PD_OUT] & reg_q[IDX_PD_OE]) |
					{27'b0, sensor_q.shift[16], 4'b0};
			end else begin
				rdata = reg_q[widx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1    <= req_type;
			word_index_s1  <= word_index;
			write_data_s1  <= write_data;
			flash_ready_s1 <= flash_ready;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				reg_q[i] <= '0;
			end
			sensor_q     <= '0;
			flash_pins_q <= '0;
		end else if (advance) begin
			if (is_write && in_range) begin
				reg_q[widx] <= write_data_s1;
			end
			sensor_q     <= sensor_d;
			flash_pins_q <= flash_d;
		end
	end

	// The pins only move when a result is loaded, so they stay steady while it waits.
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign flash_ale = flash_pins_q[2];
	assign flash_cle = flash_pins_q[1];
	assign flash_ce  = flash_pins_q[0];

	`GPTS_ASSERT_NOW(a_bits_range, clk, arst_n, 1'b1, sensor_q.bits_left <= SENSOR_BITS)
	`GPTS_ASSERT_NOW(a_in_phase_count, clk, arst_n, sensor_q.in_phase, sensor_q.bits_left != '0)
	`GPTS_ASSERT_NEXT(a_pins_hold, clk, arst_n,
		!(advance && is_write && (word_index_s1 == IDX_PA_OUT)), $stable(flash_pins_q))

endmodule

### tb/tb_gpio_port_with_spi_temp_sensor.sv
`timescale 1ns / 1ps

module tb_gpio_port_with_spi_temp_sensor;
	import gpts_pkg::*;

	localparam int NREGS = 23;
	localparam int RANDOM_REQUESTS = 1500;
	localparam int CYCLE_LIMIT = 200000;
	localparam int STEADY_FROM = 600;
	localparam int STEADY_TO = 900;

	typedef struct packed {
		logic [31:0] read_data;
		logic        ale;
		logic        cle;
		logic        ce;
	} gpio_result_t;

	// Tracks the register file, the flash pins and the sensor, and holds the results
	// that are still owed by the block, oldest first.
	class gpio_scoreboard;
		logic [31:0]  regs [NREGS];
		logic [16:0]  sensor_sr;
		logic [4:0]   sensor_left;
		logic         sensor_rx;
		logic [15:0]  sensor_cmd;
		logic [2:0]   pins;
		gpio_result_t owed_q [$];
		int           errors;
		int           checked;

		function new();
			foreach (regs[i])
				regs[i] = '0;
			sensor_sr = '0;
			sensor_left = '0;
			sensor_rx = 1'b0;
			sensor_cmd = '0;
			pins = '0;
			errors = 0;
			checked = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("%0t ns: mismatch: %s", $time, msg);
		endtask

		function void clock_sensor(logic sck, logic sdi);
			// A count of zero only happens after reset; it starts an output phase.
			if (sensor_left == 5'd0) begin
				sensor_left = SENSOR_BITS;
				sensor_rx = 1'b0;
			end
			if (!sensor_rx) begin
				if (!sck) begin
					sensor_left = sensor_left - 5'd1;
					sensor_sr = sensor_sr << 1;
					if (sensor_left == 5'd0) begin
						sensor_sr = '0;
						sensor_rx = 1'b1;
						sensor_left = SENSOR_BITS;
					end
				end
			end else if (sck) begin
				sensor_left = sensor_left - 5'd1;
				sensor_sr = {sensor_sr[15:0], sdi};
				if (sensor_left == 5'd0) begin
					sensor_cmd = sensor_sr[15:0];
					sensor_rx = 1'b0;
					sensor_left = SENSOR_BITS;
					if (sensor_cmd[7:0] == CMD_TEMP)
						sensor_sr = TEMP_WORD;
					else if (sensor_cmd[7:0] == CMD_ID)
						sensor_sr = ID_WORD;
				end
			end
		endfunction

		function void note_request(req_kind_t kind, logic [4:0] idx, logic [31:0] data,
				logic rdy);
			gpio_result_t want;
			want = '0;
			if (idx < NREGS) begin
				if (kind == REQ_WRITE) begin
					if (idx == IDX_PA_OUT)
						pins = {data[6], data[5], data[4]};
					else if (idx == IDX_PD_OUT && regs[IDX_PD_OUT][1] != data[1])
						clock_sensor(data[1], data[4]);
					regs[idx] = data;
				end else if (idx == IDX_PA_IN) begin
					want.read_data = (regs[IDX_PA_OUT] & regs[IDX_PA_OE]) | {24'd0, rdy, 7'd0};
				end else if (idx == IDX_PD_IN) begin
					want.read_data = (regs[IDX_PD_OUT] & regs[IDX_PD_OE]) |
						{27'd0, sensor_sr[16], 4'd0};
				end else begin
					want.read_data = regs[idx];
				end
			end
			{want.ale, want.cle, want.ce} = pins;
			owed_q.push_back(want);
		endfunction

		task check_result(gpio_result_t got);
			gpio_result_t want;
			checked++;
			if (owed_q.size() == 0) begin
				report($sformatf("result %h arrived with no request outstanding", got));
				return;
			end
			want = owed_q.pop_front();
			if (got.read_data !== want.read_data)
				report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
			if (got.ale !== want.ale)
				report($sformatf("flash_ale %b, expected %b", got.ale, want.ale));
			if (got.cle !== want.cle)
				report($sformatf("flash_cle %b, expected %b", got.cle, want.cle));
			if (got.ce !== want.ce)
				report($sformatf("flash_ce %b, expected %b", got.ce, want.ce));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = 1'b0;
	logic [4:0]  word_index = '0;
	logic [31:0] write_data = '0;
	logic        flash_ready = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] read_data;
	logic        flash_ale;
	logic        flash_cle;
	logic        flash_ce;

	gpio_scoreboard sb = new();
	int n_requests = 0;
	int n_frames = 0;
	int n_broken = 0;
	int n_temp = 0;
	int n_id = 0;
	int n_echo = 0;
	int unsigned cycle_count = 0;

	gpio_port_with_spi_temp_sensor #(.NUM_REGS(NREGS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.word_index(word_index),
		.write_data(write_data),
		.flash_ready(flash_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.flash_ale(flash_ale),
		.flash_cle(flash_cle),
		.flash_ce(flash_ce)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// No idling on either side while this window of requests goes through.
	function automatic bit steady_stretch();
		return n_requests >= STEADY_FROM && n_requests < STEADY_TO;
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result({read_data, flash_ale, flash_cle, flash_ce});
		out_ready <= steady_stretch() || $urandom_range(99) >= 29;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("tb_gpio_port_with_spi_temp_sensor: errors");
			$finish;
		end
	end

	task automatic send_request(req_kind_t kind, logic [4:0] idx, logic [31:0] data,
			logic rdy);
		while (!steady_stretch() && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		word_index <= idx;
		write_data <= data;
		flash_ready <= rdy;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(kind, idx, data, rdy);
		n_requests++;
	endtask

	task automatic pd_write(logic sck, logic sdi);
		logic [31:0] word;
		word = $urandom;
		word[1] = sck;
		word[4] = sdi;
		send_request(REQ_WRITE, IDX_PD_OUT, word, 1'($urandom_range(1)));
	endtask

	task automatic pd_sample();
		send_request(REQ_READ, IDX_PD_IN, $urandom, 1'($urandom_range(1)));
	endtask

	// One full sensor transfer: falling edges while the sensor talks, with the data line
	// sampled before each, then rising edges that carry a 16-bit command.
	task automatic sensor_frame();
		logic [31:0] oe;
		logic [15:0] cmd;
		cmd = 16'($urandom);
		case ($urandom_range(2))
			0: cmd[7:0] = CMD_TEMP;
			1: cmd[7:0] = CMD_ID;
			default: ;
		endcase
		if (cmd[7:0] == CMD_TEMP)
			n_temp++;
		else if (cmd[7:0] == CMD_ID)
			n_id++;
		else
			n_echo++;
		oe = $urandom;
		// Keep the output enable off bit 4 most of the time so the sensor bit shows.
		if ($urandom_range(3) != 0)
			oe[4] = 1'b0;
		send_request(REQ_WRITE, IDX_PD_OE, oe, 1'($urandom_range(1)));
		for (int i = 0; i < 16; i++) begin
			pd_write(1'b1, $urandom_range(7) == 0);
			pd_sample();
			pd_write(1'b0, $urandom_range(7) == 0);
		end
		for (int i = 15; i >= 0; i--) begin
			pd_write(1'b0, cmd[i]);
			pd_write(1'b1, cmd[i]);
			if ($urandom_range(3) == 0)
				pd_sample();
		end
		pd_sample();
		n_frames++;
	endtask

	task automatic broken_sequence();
		int edges;
		edges = $urandom_range(20, 1);
		for (int i = 0; i < edges; i++) begin
			pd_write(1'($urandom_range(1)), 1'($urandom_range(1)));
			if ($urandom_range(2) == 0)
				pd_sample();
		end
		n_broken++;
	endtask

	task automatic noise_burst();
		logic [4:0] idx;
		int count;
		count = $urandom_range(12, 4);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					case ($urandom_range(5))
						0: idx = IDX_PA_OUT;
						1: idx = IDX_PA_IN;
						2: idx = IDX_PA_OE;
						3: idx = IDX_PD_OUT;
						4: idx = IDX_PD_IN;
						default: idx = IDX_PD_OE;
					endcase
				end
				9: idx = 5'($urandom_range(31, NREGS));
				default: idx = 5'($urandom_range(NREGS - 1));
			endcase
			send_request(req_kind_t'($urandom_range(1)), idx, $urandom,
				1'($urandom_range(1)));
		end
	endtask

	initial begin
		int stop_at;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Port A: ready pin alone, then all-ones latch with a partial enable.
		send_request(REQ_READ, IDX_PA_IN, 32'h0, 1'b1);
		send_request(REQ_WRITE, IDX_PA_OUT, 32'hffff_ffff, 1'b0);
		send_request(REQ_WRITE, IDX_PA_OE, 32'h0000_ffff, 1'b1);
		send_request(REQ_READ, IDX_PA_IN, 32'hffff_ffff, 1'b0);
		send_request(REQ_READ, IDX_PA_OUT, 32'h0, 1'b0);
		send_request(REQ_WRITE, IDX_PA_OUT, 32'h0000_0050, 1'b0);
		send_request(REQ_WRITE, IDX_PA_OUT, 32'hffff_ffaf, 1'b1);
		// A write to the input word lands in the file but the read stays computed.
		send_request(REQ_WRITE, IDX_PA_IN, 32'hdead_beef, 1'b0);
		send_request(REQ_READ, IDX_PA_IN, 32'h0, 1'b1);
		send_request(REQ_WRITE, 5'(NREGS - 1), 32'hffff_ffff, 1'b0);
		send_request(REQ_READ, 5'(NREGS - 1), 32'h0, 1'b0);
		// Indexes past the file: writes dropped, reads give zero.
		send_request(REQ_WRITE, 5'd31, 32'h1234_5678, 1'b1);
		send_request(REQ_READ, 5'd31, 32'hffff_ffff, 1'b1);
		send_request(REQ_READ, 5'(NREGS), 32'h0, 1'b0);
		// Port D: first clock edge after reset restarts the count; a rising edge in the
		// output phase does nothing, a falling one shifts, and a rewrite without a
		// toggle leaves the sensor alone.
		send_request(REQ_WRITE, IDX_PD_OE, 32'hffff_ffff, 1'b0);
		send_request(REQ_READ, IDX_PD_IN, 32'h0, 1'b0);
		send_request(REQ_WRITE, IDX_PD_OUT, 32'h0000_0002, 1'b0);
		send_request(REQ_WRITE, IDX_PD_OUT, 32'h0000_0010, 1'b0);
		send_request(REQ_WRITE, IDX_PD_OUT, 32'h0000_0000, 1'b0);
		send_request(REQ_WRITE, IDX_PD_IN, 32'hffff_ffff, 1'b1);
		send_request(REQ_READ, IDX_PD_IN, 32'h0, 1'b1);
		send_request(REQ_READ, IDX_PD_OUT, 32'h0, 1'b0);
		send_request(REQ_WRITE, IDX_PA_OUT, 32'h0, 1'b0);

		stop_at = n_requests + RANDOM_REQUESTS;
		while (n_requests < stop_at) begin
			case ($urandom_range(99)) inside
				[0:69]: sensor_frame();
				[70:84]: broken_sequence();
				default: noise_burst();
			endcase
		end
		in_valid <= 1'b0;

		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("%0d requests sent, %0d results checked, %0d mismatches", n_requests,
			sb.checked, sb.errors);
		$display("%0d sensor frames (%0d temperature, %0d id, %0d echo), %0d broken sequences",
			n_frames, n_temp, n_id, n_echo, n_broken);
		if (sb.errors == 0)
			$display("tb_gpio_port_with_spi_temp_sensor: clean");
		else
			$display("tb_gpio_port_with_spi_temp_sensor: errors");
		$finish;
	end

endmodule
